@@ src/radome_attack_angle_assert.svh @@
// assertion macros for the radome attack angle block
// used by the port checker; no other dependencies
`ifndef RADOME_ATTACK_ANGLE_ASSERT_SVH
`define RADOME_ATTACK_ANGLE_ASSERT_SVH
`define RAA_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define RAA_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ src/raa_pkg.sv @@
// shared types and constants for the radome attack angle block
// no dependencies
`default_nettype none
package raa_pkg;
  localparam logic [1:0] MODE_LIN  = 2'd0;
  localparam logic [1:0] MODE_CORR = 2'd1;
  localparam logic [1:0] MODE_POLY = 2'd2;
  localparam logic [1:0] MODE_ZERO = 2'd3;
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_SLOPE  = 2'd2;
  localparam int Q24 = 24;
  localparam logic [24:0] K_CORR0 = 25'd10393485;
  localparam logic [24:0] K_CORR1 = 25'd17239932;
  localparam logic [24:0] K_CORR_CAP = 25'd7046431;
  localparam logic [24:0] K_POLY0 = 25'd1207601;
  localparam logic [24:0] K_POLY1 = 25'd555381;
  localparam logic [24:0] K_POLY2 = 25'd183229;
  localparam logic [57:0] QUOT_LIMIT = 58'd1 << 56;
  // request classified by the front part
  typedef struct packed {
    logic        zero;   // low pressure or mode three
    logic [1:0]  mode;
    logic signed [31:0] dp;
    logic [30:0] q;
    logic [20:0] m2;
  } raa_req_t;
endpackage
`default_nettype wire

@@ src/raa_front.sv @@
// front part: accepts requests, classifies them, holds a two-entry queue
// depends on raa_pkg
`default_nettype none
module raa_front import raa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [31:0] in_dp,
  input  wire logic [30:0] in_q,
  input  wire logic [20:0] in_m2,
  input  wire logic [1:0]  mode,
  output logic             q_valid,
  input  wire logic        q_take,
  output raa_req_t         q_req
);
  localparam logic [30:0] Q_MIN = 31'(11) << (FRAC_BITS - 1);
  raa_req_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  raa_req_t req;
  logic push, pop;
  always_comb begin
    req.zero = (in_q <= Q_MIN) || (mode == MODE_ZERO);
    req.mode = mode;
    req.dp = in_dp;
    req.q = in_q;
    req.m2 = in_m2;
  end
  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_take;
  assign q_req = mem_r[rp_r];
  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= req;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
  end
endmodule
`default_nettype wire

@@ src/raa_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with side band
// depends on raa_pkg; quotient of 58-bit magnitude over 62-bit divisor
`default_nettype none
module raa_div import raa_pkg::*; #(
  parameter int NB = 58,
  parameter int DB = 62,
  parameter int SB = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NB-1:0] num,
  input  wire logic [DB-1:0] den,
  input  wire logic [SB-1:0] side_in,
  output logic [NB-1:0]      quot,
  output logic [SB-1:0]      side_out
);
  logic [NB-1:0] n_r [NB+1];
  logic [DB:0]   r_r [NB+1];
  logic [DB-1:0] d_r [NB+1];
  logic [SB-1:0] s_r [NB+1];
  always_comb begin
    n_r[0] = num; r_r[0] = '0; d_r[0] = den; s_r[0] = side_in;
  end
  for (genvar i = 0; i < NB; i++) begin : g_st
    logic [DB:0] sh, df;
    always_comb begin
      sh = {r_r[i][DB-1:0], n_r[i][NB-1]};
      df = sh - {1'b0, d_r[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i+1] <= d_r[i];
        s_r[i+1] <= s_r[i];
        if (!df[DB]) begin
          r_r[i+1] <= df;
          n_r[i+1] <= {n_r[i][NB-2:0], 1'b1};
        end else begin
          r_r[i+1] <= sh;
          n_r[i+1] <= {n_r[i][NB-2:0], 1'b0};
        end
      end
    end
  end
  assign quot = n_r[NB];
  assign side_out = s_r[NB];
endmodule
`default_nettype wire

@@ src/raa_back.sv @@
// back part: pipelined divisions, root and polynomial, output register
// depends on raa_pkg and raa_div
`default_nettype none
module raa_back import raa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_take,
  input  raa_req_t         q_req,
  input  wire logic signed [31:0] offset,
  input  wire logic [30:0] slope,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_angle,
  output logic             out_sat
);
  // root stages, polynomial and denominator stages, then two divider pipes
  localparam int RW = 32;
  localparam int DN = 100;
  localparam int LAT = RW + 2 + 2 * DN;
  // the whole pipe freezes while a result waits on a stalled receiver
  logic en;
  logic [LAT-1:0] vld_r;
  logic busy;
  assign busy = out_valid && out_stall;
  assign en = !busy;
  assign q_take = en;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], q_valid};
  end

  // stage a: root of m2 via 32-step pipelined isqrt (result Q24, 24+ bits)
  // root = isqrt(m2 << (48-F)); operand up to 21+48-16 = 53 bits, root 27 bits
  localparam int XW = 2 * RW;
  logic [XW-1:0] sx_r [RW+1];
  logic [RW-1:0] sr_r [RW+1];
  raa_req_t sq_r [RW+1];
  always_comb begin
    sx_r[0] = XW'(q_req.m2) << (2 * Q24 - FRAC_BITS);
    sr_r[0] = '0;
    sq_r[0] = q_req;
  end
  for (genvar i = 0; i < RW; i++) begin : g_rt
    logic [RW-1:0] tr;
    logic [XW-1:0] tsq;
    always_comb begin
      tr = sr_r[i] | (RW'(1) << (RW - 1 - i));
      tsq = XW'(tr) * XW'(tr);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[i+1] <= sx_r[i];
        sq_r[i+1] <= sq_r[i];
        sr_r[i+1] <= (tsq <= sx_r[i]) ? tr : sr_r[i];
      end
    end
  end
  // note: the root search above takes RW stages ahead of the divisions
  raa_req_t a_req;
  logic [RW-1:0] root;
  assign a_req = sq_r[RW];
  assign root = sr_r[RW];

  // stage b: polynomial products
  logic [56:0] p1_r, p2_r;
  raa_req_t b_req;
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= 57'(K_POLY1) * 57'(root);
      p2_r <= 57'(K_POLY2) * 57'(a_req.m2);
      b_req <= a_req;
    end
  end
  logic signed [33:0] poly;
  assign poly = 34'(K_POLY0) - 34'(p1_r >> Q24) + 34'(p2_r >> FRAC_BITS);
  // stage c: denominator
  logic [61:0] den_r;
  raa_req_t c_req;
  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= (poly > 0) ? 62'(b_req.q) * 62'(poly[30:0]) : '0;
      c_req <= b_req;
    end
  end

  // first division: ratio (modes 0,1) or full result (mode 2)
  // numerator |a| << sh, quotient clamped at 2^56
  logic neg1;
  logic [31:0] mag1;
  logic [61:0] d1;
  logic [5:0]  sh1;
  logic sat_pre;
  always_comb begin
    neg1 = c_req.dp[31];
    mag1 = neg1 ? 32'(-c_req.dp) : 32'(c_req.dp);
    if (c_req.mode == MODE_POLY) begin
      d1 = den_r; sh1 = 6'(FRAC_BITS + Q24);
    end else begin
      d1 = 62'(c_req.q); sh1 = 6'(Q24);
    end
    sat_pre = (d1 == '0);
  end
  // exact quotient fits: |a|*2^sh < 2^(32+40)=2^72; split into
  // integer compare: quotient >= 2^56 iff mag<<sh >= d<<56
  logic [127:0] big_n, big_d;
  logic ovf1;
  always_comb begin
    big_n = 128'(mag1) << sh1;
    big_d = 128'(d1) << 56;
    ovf1 = (big_n >= big_d);
  end
  logic [99:0] divn;
  assign divn = 100'(mag1) << sh1;
  localparam int SB1 = $bits(raa_req_t) + 3;
  logic [99:0] q1w;
  logic [SB1-1:0] s1o;
  raa_req_t d1_req;
  logic d1_neg, d1_ovf, d1_z;
  raa_div #(.NB(DN), .DB(62), .SB(SB1)) u_div1 (
    .clk(clk), .en(en), .num(divn), .den(d1),
    .side_in({c_req, neg1, ovf1 || sat_pre, sat_pre}),
    .quot(q1w), .side_out(s1o)
  );
  assign {d1_req, d1_neg, d1_ovf, d1_z} = s1o;
  logic [56:0] q1m;
  logic signed [58:0] v1;
  always_comb begin
    if (d1_z) q1m = (d1_req.dp == 0) ? '0 : 57'(QUOT_LIMIT);
    else if (d1_ovf) q1m = 57'(QUOT_LIMIT);
    else q1m = q1w[56:0];
    v1 = d1_neg ? -59'(q1m) : 59'(q1m);
  end

  // second division for modes 0,1: (ratio + offset) << F / slope
  logic signed [59:0] n2s;
  logic neg2;
  logic [59:0] mag2;
  logic ovf2, z2;
  logic [127:0] bn2, bd2;
  always_comb begin
    n2s = 60'(v1) + 60'(offset);
    neg2 = n2s[59];
    mag2 = neg2 ? 60'(-n2s) : 60'(n2s);
    z2 = (slope == '0);
    bn2 = 128'(mag2) << FRAC_BITS;
    bd2 = 128'(slope) << 56;
    ovf2 = (bn2 >= bd2);
  end
  localparam int SB2 = $bits(raa_req_t) + 59 + 5;
  logic [99:0] q2w;
  logic [SB2-1:0] s2o;
  raa_req_t e_req;
  logic signed [58:0] e_v1;
  logic e_neg, e_ovf, e_z, e_nz, e_f1;
  raa_div #(.NB(DN), .DB(62), .SB(SB2)) u_div2 (
    .clk(clk), .en(en), .num(100'(mag2) << FRAC_BITS), .den(62'(slope)),
    .side_in({d1_req, v1, neg2, ovf2 || z2, z2, mag2 != 0, d1_z}),
    .quot(q2w), .side_out(s2o)
  );
  assign {e_req, e_v1, e_neg, e_ovf, e_z, e_nz, e_f1} = s2o;

  // correction and final selection
  logic [56:0] q2m;
  logic signed [59:0] v2, corr, vf;
  logic [45:0] cp;
  logic flag;
  logic signed [31:0] ang;
  always_comb begin
    if (e_z) q2m = e_nz ? 57'(QUOT_LIMIT) : '0;
    else if (e_ovf) q2m = 57'(QUOT_LIMIT);
    else q2m = q2w[56:0];
    v2 = e_neg ? -60'(q2m) : 60'(q2m);
    cp = 46'(K_CORR1) * 46'(e_req.m2);
    corr = 60'(K_CORR0) - 60'(cp >> FRAC_BITS);
    if (corr > $signed(60'(K_CORR_CAP))) corr = 60'(K_CORR_CAP);
    corr = corr >>> (Q24 - FRAC_BITS);
    flag = e_f1;
    unique case (e_req.mode)
      MODE_LIN:  begin vf = v2; flag = e_f1 || e_z; end
      MODE_CORR: begin vf = v2 + corr; flag = e_f1 || e_z; end
      MODE_POLY: vf = 60'(e_v1);
      default:   vf = '0;
    endcase
    if (e_req.zero) begin vf = '0; flag = 1'b0; end
    if (vf > 60'sd2147483647) begin ang = 32'h7fffffff; flag = 1'b1; end
    else if (vf < -60'sd2147483648) begin ang = 32'h80000000; flag = 1'b1; end
    else ang = vf[31:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_angle <= ang;
      out_sat <= flag;
    end
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= vld_r[LAT-1];
  end
endmodule
`default_nettype wire

@@ src/radome_attack_angle.sv @@
// top level of the radome attack angle block
// depends on raa_pkg, raa_front, raa_back
//
// usage: one input request per sample (differential pressure Q16.16,
// dynamic pressure UQ15.16, mach squared UQ5.16) on the in_ channel; one
// result (attack angle and saturated flag) per request on the out_ channel.
// a request is taken when valid is high and stall is low.
// throughput: one request per cycle while out_stall is low; set by the
// pipelined root search and two pipelined dividers, one quotient bit per stage.
// from accept to result a request passes the queue, the 32 root stages, two
// for the polynomial and denominator, 100 per divider and the output register.
// a stalled receiver holds the output register and freezes the back pipe;
// the two-entry queue then fills and in_stall rises.
// reset (synchronous, rst_n low) empties the queue and the pipe and loads
// the register defaults: mode 0, offset 6447484, slope 1116188.
// registers: 0 mode, 1 offset, 2 slope at byte addresses 0, 4, 8;
// write only while the block is idle.
`default_nettype none
module radome_attack_angle import raa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [31:0] in_differential_pressure,
  input  wire logic [30:0] in_dynamic_pressure,
  input  wire logic [20:0] in_mach_squared,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_attack_angle,
  output logic             out_saturated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [1:0] mode_r;
  logic signed [31:0] offset_r;
  logic [30:0] slope_r;
  logic [1:0] ridx;
  assign pready = 1'b1;
  assign ridx = paddr[3:2];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LIN;
      offset_r <= 32'sd6447484;
      slope_r <= 31'd1116188;
    end else if (psel && penable && pwrite) begin
      priority case (ridx)
        REG_MODE:   mode_r <= pwdata[1:0];
        REG_OFFSET: offset_r <= pwdata;
        REG_SLOPE:  slope_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (ridx)
      REG_MODE:   prdata = {30'd0, mode_r};
      REG_OFFSET: prdata = offset_r;
      REG_SLOPE:  prdata = {1'b0, slope_r};
      default:    prdata = '0;
    endcase
  end

  logic q_valid, q_take;
  raa_req_t q_req;
  raa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_dp(in_differential_pressure), .in_q(in_dynamic_pressure),
    .in_m2(in_mach_squared), .mode(mode_r),
    .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
  );
  raa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
    .q_req(q_req), .offset(offset_r), .slope(slope_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_angle(out_attack_angle), .out_sat(out_saturated)
  );
endmodule
`default_nettype wire

@@ src/raa_checker.sv @@
// port checker for the radome attack angle block, bound to the top level
// depends on radome_attack_angle_assert.svh
`default_nettype none
`include "radome_attack_angle_assert.svh"
module raa_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic signed [31:0] out_attack_angle,
  input wire logic out_saturated,
  input wire logic pready
);
  `RAA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `RAA_ASSERT_IMPL(a_rdy, clk, rst_n, 1'b1, pready)
  `RAA_ASSERT_NEXT(a_stable, clk, rst_n, out_valid && out_stall,
    $stable(out_attack_angle) && $stable(out_saturated))
  `RAA_ASSERT_NEXT(a_rst, clk, 1'b1, !rst_n, !out_valid && !in_stall)
endmodule
bind radome_attack_angle raa_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_attack_angle(out_attack_angle), .out_saturated(out_saturated),
  .pready(pready)
);
`default_nettype wire
